[rtl/core/cmmt_pkg.sv]
package cmmt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 32;

   localparam int ID_W      = 29;
   localparam int PAYLOAD_W = 64;
   localparam int LEN_W     = 4;
   localparam int TIME_W    = 32;

   localparam logic MODE_STORE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic                 mode;
      logic [ID_W-1:0]      can_id;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     payload_length;
      logic [TIME_W-1:0]    receive_time;
   } cmmt_req_type;

   typedef struct packed {
      logic                 success;
      logic [ID_W-1:0]      found_id;
      logic [PAYLOAD_W-1:0] found_payload;
      logic [LEN_W-1:0]     found_length;
      logic [TIME_W-1:0]    found_time;
   } cmmt_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      entry_id;
      logic [PAYLOAD_W-1:0] entry_payload;
      logic [LEN_W-1:0]     entry_length;
      logic [TIME_W-1:0]    entry_time;
   } cmmt_entry_type;

   typedef struct packed {
      logic           lookup;
      cmmt_entry_type entry;
   } cmmt_item_type;

   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[rtl/core/cmmt_front.sv]
module cmmt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cmmt_pkg::cmmt_req_type req_payload,
   output logic                   item_valid,
   input  logic                   item_ready,
   output cmmt_pkg::cmmt_item_type item
);
   import cmmt_pkg::*;

   cmmt_item_type     queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   cmmt_item_type     new_item;
   logic              push, pop;

   always_comb begin
      new_item.lookup              = (req_payload.mode == MODE_LOOKUP);
      new_item.entry.entry_id      = req_payload.can_id;
      new_item.entry.entry_payload = req_payload.payload;
      new_item.entry.entry_length  = req_payload.payload_length;
      new_item.entry.entry_time    = req_payload.receive_time;
   end

   assign req_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/core/cmmt_engine.sv]
module cmmt_engine #(
   parameter int TABLE_DEPTH = cmmt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  cmmt_pkg::cmmt_item_type item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cmmt_pkg::cmmt_rsp_type  rsp_payload
);
   import cmmt_pkg::*;

   localparam int IDX_W = idx_width(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   cmmt_entry_type    mem [TABLE_DEPTH];

   logic [1:0]       state_ff, state_in;
   cmmt_item_type    cur_ff, cur_in;
   logic [CNT_W-1:0] rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] chk_addr_ff, chk_addr_in;
   cmmt_entry_type   rdata_ff;
   cmmt_rsp_type     res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cmmt_rsp_type     rsp_ff, rsp_in;

   logic             hit, miss, full, rd_issue, mem_we, out_free;
   logic [IDX_W-1:0] waddr;

   assign item_ready  = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // entries fill as a prefix; a scan ends at the fill count
   assign hit      = (state_ff == ST_SCAN) && chk_valid_ff &&
                     (rdata_ff.entry_id == cur_ff.entry.entry_id);
   assign miss     = (state_ff == ST_SCAN) && !hit && (rd_addr_ff == cnt_ff);
   assign full     = (cnt_ff == CNT_W'(TABLE_DEPTH));
   assign rd_issue = (state_ff == ST_SCAN) && !hit && (rd_addr_ff < cnt_ff);
   assign mem_we   = !cur_ff.lookup && (hit || (miss && !full));
   assign waddr    = hit ? chk_addr_ff : cnt_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rd_addr_in   = rd_addr_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = rd_issue;
      chk_addr_in  = rd_addr_ff[IDX_W-1:0];
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               cur_in     = item;
               rd_addr_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (hit || miss) begin
               res_in = '0;
               if (cur_ff.lookup) begin
                  res_in.success = hit;
                  if (hit) begin
                     res_in.found_id      = rdata_ff.entry_id;
                     res_in.found_payload = rdata_ff.entry_payload;
                     res_in.found_length  = rdata_ff.entry_length;
                     res_in.found_time    = rdata_ff.entry_time;
                  end
               end else begin
                  res_in.success = hit || !full;
               end
               if (miss && !full && !cur_ff.lookup) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_addr_ff   <= '0;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      chk_addr_ff <= chk_addr_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rdata_ff <= mem[rd_addr_ff[IDX_W-1:0]];
      end
      if (mem_we) begin
         mem[waddr] <= cur_ff.entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count above table depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         ($past(state_ff) == ST_SCAN) && !$past(cur_ff.lookup) &&
         (cnt_ff == CNT_W'($past(cnt_ff) + 1'b1)))
      else $error("fill count changed outside a store miss");

   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WAIT))
      else $error("response loaded without a finished scan");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !rd_issue |-> (hit || miss))
      else $error("scan stalled with no decision");

endmodule

[rtl/core/can_message_mailbox_table.sv]
// Last-value CAN receive table. A store transaction (mode 0) overwrites the
// entry holding the same identifier or appends a new one, and reports
// success 0 when the identifier is new and all TABLE_DEPTH entries are
// taken; a lookup transaction (mode 1) returns the stored frame with
// success 1, or all zeros on a miss. Each transaction is scanned through
// the single-port entry memory at one entry per clock, stopping at the
// first match or at the fill count; the engine takes no new transaction
// until its result has moved into the output register. A two-entry queue
// in front takes new requests while a scan runs, and the output register
// holds a result until it is taken. Entries are tracked by a fill count,
// so no clearing pass follows reset.
module can_message_mailbox_table #(
   parameter int TABLE_DEPTH = cmmt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cmmt_pkg::cmmt_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cmmt_pkg::cmmt_rsp_type rsp_payload
);
   import cmmt_pkg::*;

   logic          item_valid;
   logic          item_ready;
   cmmt_item_type item;

   cmmt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item)
   );

   cmmt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
